// ===== design/datl_pkg.sv =====
// Shared types and codes for the double-array trie lookup.
package datl_pkg;

  // item kinds
  localparam logic [1:0] KIND_MAP  = 2'd0;
  localparam logic [1:0] KIND_TRIE = 2'd1;
  localparam logic [1:0] KIND_CHAR = 2'd2;

  // result codes
  localparam logic [1:0] RES_PREFIX   = 2'd0;
  localparam logic [1:0] RES_FOUND    = 2'd1;
  localparam logic [1:0] RES_MISMATCH = 2'd2;

  localparam logic [12:0] ALPHA_RESET = 13'd4096;
  localparam logic [11:0] ROOT_BASE   = 12'd1;
  localparam logic [12:0] CHECK_FREE  = 13'h1fff;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRIE,
    ST_EVAL
  } datl_state_t;

  typedef struct packed {
    logic [11:0] base;
    logic        leaf;
    logic [12:0] check;
  } trie_entry_t;

endpackage

// ===== design/double_array_trie_lookup.sv =====
// Double-array trie lookup: code map and trie memories plus the per-key walk.
//
// Items enter on start while busy is low. A load (code map or trie entry) is written
// at its accept edge. A key character needs the code map read at the accept edge and
// the trie entry read in the cycle after; they form a dependent chain, since the next
// character needs the base of this one's entry. busy is high in the cycle after a
// character is accepted, so the next character waits until this one's trie entry is
// read. On the final character of a key a single result is shown on result_code with
// result_valid high for one cycle, registered at the end of the ST_EVAL step; the
// receiver cannot stall it. After reset a clearing pass writes both memories, one
// entry per cycle, with busy high. The alphabet size register may be written at any
// time, best while no key is in flight.
module double_array_trie_lookup
  import datl_pkg::*;
#(
  parameter int TRIE_DEPTH     = 4096,
  parameter int ALPHABET_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [11:0] index,
  input  logic [11:0] code_value,
  input  logic [11:0] entry_base,
  input  logic        entry_leaf,
  input  logic signed [12:0] entry_check,
  input  logic [15:0] char_code,
  input  logic        last_char,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,
  output logic        result_valid,
  output logic [1:0]  result_code
);

  // only the first 4096 entries are reachable by the 12-bit write index
  localparam int MAP_WORDS   = (ALPHABET_DEPTH < 4096) ? ALPHABET_DEPTH : 4096;
  localparam int TRIE_WORDS  = (TRIE_DEPTH < 4096) ? TRIE_DEPTH : 4096;
  localparam int CLEAR_WORDS = (MAP_WORDS > TRIE_WORDS) ? MAP_WORDS : TRIE_WORDS;
  localparam int MAP_AW      = $clog2(MAP_WORDS);
  localparam int TRIE_AW     = $clog2(TRIE_WORDS);
  localparam int CLR_W       = $clog2(CLEAR_WORDS);

  logic [11:0]  code_map [MAP_WORDS];
  trie_entry_t  trie_mem [TRIE_WORDS];

  datl_state_t  state, state_next;
  logic [CLR_W-1:0] clear_cnt;
  logic         clear_done;

  logic [12:0]  alphabet_size;
  logic [11:0]  walk_base, walk_base_next;
  logic [11:0]  walk_parent, walk_parent_next;
  logic         walk_failed, walk_failed_next;
  logic         walk_leaf, walk_leaf_next;

  logic         accept;
  logic         is_char;
  logic         char_ok;
  logic         char_last;
  logic         map_hit;
  logic [11:0]  map_rdata;
  logic [11:0]  map_code;
  logic [12:0]  pos;
  logic [11:0]  pos_reg;
  logic         pos_ok;
  trie_entry_t  trie_rdata;
  logic         entry_match;

  logic         map_we, trie_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [TRIE_AW-1:0] trie_waddr;
  logic [11:0]  map_wdata;
  trie_entry_t  trie_wdata;

  assign accept     = start && !busy;
  assign is_char    = (kind == KIND_CHAR);
  assign cfg_ready  = 1'b1;
  assign clear_done = (clear_cnt == CLR_W'(CLEAR_WORDS - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (accept && is_char) state_next = ST_TRIE;
      ST_TRIE:  state_next = ST_EVAL;
      ST_EVAL: begin
        if (accept && is_char) state_next = ST_TRIE;
        else state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    unique case (state)
      ST_CLEAR: busy = 1'b1;
      ST_TRIE:  busy = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_EVAL:  busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clear_cnt <= clear_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_size <= ALPHA_RESET;
    end else if (cfg_valid && cfg_ready) begin
      alphabet_size <= cfg_data;
    end
  end

  // memory write ports: clearing pass or load transfer
  always_comb begin
    map_we     = 1'b0;
    map_waddr  = index[MAP_AW-1:0];
    map_wdata  = code_value;
    trie_we    = 1'b0;
    trie_waddr = index[TRIE_AW-1:0];
    trie_wdata = '{base: entry_base, leaf: entry_leaf, check: entry_check};
    if (state == ST_CLEAR) begin
      map_we     = (32'(clear_cnt) < MAP_WORDS);
      map_waddr  = clear_cnt[MAP_AW-1:0];
      map_wdata  = '0;
      trie_we    = (32'(clear_cnt) < TRIE_WORDS);
      trie_waddr = clear_cnt[TRIE_AW-1:0];
      trie_wdata = '{base: 12'd0, leaf: 1'b0, check: CHECK_FREE};
    end else if (accept) begin
      map_we  = (kind == KIND_MAP) && ({20'd0, index} < 32'(MAP_WORDS));
      trie_we = (kind == KIND_TRIE) && ({20'd0, index} < 32'(TRIE_WORDS));
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) code_map[map_waddr] <= map_wdata;
    if (accept) map_rdata <= code_map[char_code[MAP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (trie_we) trie_mem[trie_waddr] <= trie_wdata;
    if (state == ST_TRIE) trie_rdata <= trie_mem[pos[TRIE_AW-1:0]];
  end

  // character side information captured at the accept edge
  always_ff @(posedge clk) begin
    if (accept) begin
      char_last <= last_char;
      char_ok   <= ({3'd0, char_code} < {6'd0, alphabet_size})
                   && ({16'd0, char_code} < 32'(ALPHABET_DEPTH));
      // characters past the stored map read as code zero
      map_hit   <= ({16'd0, char_code} < 32'(MAP_WORDS));
    end
  end

  assign map_code = map_hit ? map_rdata : 12'd0;
  assign pos      = {1'b0, walk_base} + {1'b0, map_code};

  always_ff @(posedge clk) begin
    if (state == ST_TRIE) begin
      pos_reg <= pos[11:0];
      pos_ok  <= ({19'd0, pos} < 32'(TRIE_WORDS));
    end
  end

  // parent indexes are never negative, so a free entry cannot match
  assign entry_match = (trie_rdata.check == {1'b0, walk_parent});

  always_comb begin
    walk_base_next   = walk_base;
    walk_parent_next = walk_parent;
    walk_failed_next = walk_failed;
    walk_leaf_next   = walk_leaf;
    if (!walk_failed) begin
      if (char_ok && pos_ok && entry_match) begin
        walk_leaf_next   = trie_rdata.leaf;
        walk_base_next   = trie_rdata.base;
        walk_parent_next = pos_reg;
      end else begin
        walk_failed_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_base    <= ROOT_BASE;
      walk_parent  <= '0;
      walk_failed  <= 1'b0;
      walk_leaf    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (state == ST_EVAL) begin
        if (char_last) begin
          walk_base    <= ROOT_BASE;
          walk_parent  <= '0;
          walk_failed  <= 1'b0;
          walk_leaf    <= 1'b0;
          result_valid <= 1'b1;
        end else begin
          walk_base   <= walk_base_next;
          walk_parent <= walk_parent_next;
          walk_failed <= walk_failed_next;
          walk_leaf   <= walk_leaf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL && char_last) begin
      priority if (walk_failed_next) result_code <= RES_MISMATCH;
      else if (walk_leaf_next) result_code <= RES_FOUND;
      else result_code <= RES_PREFIX;
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the double-array trie lookup: random tries and keys over several alphabet sizes.
module tb_top
  import datl_pkg::*;
();

  localparam int DEPTH = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [1:0]         kind;
    logic [11:0]        index;
    logic [11:0]        code_value;
    logic [11:0]        entry_base;
    logic               entry_leaf;
    logic signed [12:0] entry_check;
    logic [15:0]        char_code;
    logic               last_char;
  } dat_item_t;

  typedef struct {
    int slot;
    int up;
    int ch;
    int depth;
    int base;
    int kids;
    bit leaf;
  } trie_node_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] kind = '0;
  logic [11:0] index = '0;
  logic [11:0] code_value = '0;
  logic [11:0] entry_base = '0;
  logic entry_leaf = 1'b0;
  logic signed [12:0] entry_check = '0;
  logic [15:0] char_code = '0;
  logic last_char = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [12:0] cfg_data = '0;
  logic result_valid;
  logic [1:0] result_code;

  double_array_trie_lookup uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .index(index),
    .code_value(code_value),
    .entry_base(entry_base),
    .entry_leaf(entry_leaf),
    .entry_check(entry_check),
    .char_code(char_code),
    .last_char(last_char),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .result_code(result_code)
  );

  always #5 clk = ~clk;

  // predicted block state
  logic [11:0] map_tbl [DEPTH];
  logic [11:0] base_tbl [DEPTH];
  logic leaf_tbl [DEPTH];
  logic signed [12:0] check_tbl [DEPTH];
  int cur_base;
  int cur_parent;
  bit key_bad;
  bit cur_leaf;
  int alpha_lim;
  logic [1:0] expected_codes [$];

  dat_item_t todo_items [$];
  int n_queued = 0;
  int n_taken = 0;
  int n_real = 0;
  bit failed = 1'b0;

  // stimulus-side view of the trie being loaded
  int dict_ch [$];
  int dict_cd [$];
  trie_node_t nodes [$];
  bit slot_used [DEPTH];

  function automatic void apply_lookup_item(dat_item_t it);
    int ch;
    int pos;
    case (it.kind)
      KIND_MAP: map_tbl[it.index] = it.code_value;
      KIND_TRIE: begin
        base_tbl[it.index] = it.entry_base;
        leaf_tbl[it.index] = it.entry_leaf;
        check_tbl[it.index] = it.entry_check;
      end
      KIND_CHAR: begin
        ch = it.char_code;
        if (!key_bad) begin
          if (ch >= alpha_lim || ch >= DEPTH) begin
            key_bad = 1'b1;
          end else begin
            pos = cur_base + int'(map_tbl[ch]);
            if (pos >= DEPTH) begin
              key_bad = 1'b1;
            end else if (int'(check_tbl[pos]) != cur_parent) begin
              key_bad = 1'b1;
            end else begin
              cur_leaf = leaf_tbl[pos];
              cur_base = base_tbl[pos];
              cur_parent = pos;
            end
          end
        end
        if (it.last_char) begin
          if (key_bad) expected_codes.push_back(RES_MISMATCH);
          else if (cur_leaf) expected_codes.push_back(RES_FOUND);
          else expected_codes.push_back(RES_PREFIX);
          cur_base = int'(ROOT_BASE);
          cur_parent = 0;
          key_bad = 1'b0;
          cur_leaf = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  dat_item_t cur_item;
  int gap_left = 0;
  bit no_idle = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_lookup_item(cur_item);
        n_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (todo_items.size() > 0) begin
          cur_item = todo_items.pop_front();
          kind <= cur_item.kind;
          index <= cur_item.index;
          code_value <= cur_item.code_value;
          entry_base <= cur_item.entry_base;
          entry_leaf <= cur_item.entry_leaf;
          entry_check <= cur_item.entry_check;
          char_code <= cur_item.char_code;
          last_char <= cur_item.last_char;
          start <= 1'b1;
          if ($urandom_range(0, 40) == 0) no_idle = !no_idle;
          gap_left = no_idle ? 0 : $urandom_range(0, 10);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  logic [1:0] want_code;

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) begin
      if (expected_codes.size() == 0) begin
        $error("result_code: expected none, actual %0d", result_code);
        failed = 1'b1;
      end else begin
        want_code = expected_codes.pop_front();
        if (result_code !== want_code) begin
          $error("result_code: expected %0d, actual %0d", want_code, result_code);
          failed = 1'b1;
        end
      end
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic dat_item_t noise_fields(logic [1:0] k);
    dat_item_t it;
    it.kind = k;
    it.index = 12'($urandom);
    it.code_value = 12'($urandom);
    it.entry_base = 12'($urandom);
    it.entry_leaf = 1'($urandom);
    it.entry_check = 13'($urandom_range(0, 4096) - 1);
    it.char_code = 16'($urandom);
    it.last_char = 1'($urandom);
    return it;
  endfunction

  task automatic push_item(dat_item_t it);
    todo_items.push_back(it);
    n_queued++;
    if (it.kind != KIND_NONE) n_real++;
  endtask

  task automatic put_map(int idx, int cd);
    dat_item_t it;
    it = noise_fields(KIND_MAP);
    it.index = 12'(idx);
    it.code_value = 12'(cd);
    push_item(it);
  endtask

  task automatic put_trie(int idx, int b, bit lf, int chk);
    dat_item_t it;
    it = noise_fields(KIND_TRIE);
    it.index = 12'(idx);
    it.entry_base = 12'(b);
    it.entry_leaf = lf;
    it.entry_check = 13'(chk);
    push_item(it);
  endtask

  task automatic put_char(int ch, bit last);
    dat_item_t it;
    it = noise_fields(KIND_CHAR);
    it.char_code = 16'(ch);
    it.last_char = last;
    push_item(it);
  endtask

  // stray load or ignored item; keeps the loaded trie intact
  task automatic put_stray();
    int idx;
    int r;
    int cd;
    r = $urandom_range(0, 2);
    idx = $urandom_range(0, DEPTH - 1);
    if (r == 0) begin
      push_item(noise_fields(KIND_NONE));
    end else if (r == 1) begin
      cd = $urandom_range(0, 4095);
      foreach (dict_ch[m]) if (dict_ch[m] == idx) cd = dict_cd[m];
      put_map(idx, cd);
    end else begin
      if (slot_used[idx]) idx = 0;
      put_trie(idx, $urandom_range(0, 4095), 1'($urandom), $urandom_range(0, 4096) - 1);
    end
  endtask

  task automatic build_trie(int alpha);
    int n;
    int lim;
    int c;
    int cd;
    int k;
    int b;
    int j;
    int i;
    int tries;
    int maxc;
    bit wide;
    bit ok;
    bit dup;
    int kid_codes [$];
    int kid_chars [$];
    trie_node_t nd;
    lim = (alpha > 0) ? ((alpha < DEPTH) ? alpha : DEPTH) : 16;
    n = $urandom_range(1, 8);
    if (n > lim) n = lim;
    wide = ($urandom_range(0, 7) == 0);
    dict_ch.delete();
    dict_cd.delete();
    nodes.delete();
    foreach (slot_used[m]) slot_used[m] = 1'b0;
    slot_used[0] = 1'b1;
    while (dict_ch.size() < n) begin
      c = (dict_ch.size() == 0 && $urandom_range(0, 3) == 0) ? lim - 1
                                                          : $urandom_range(0, lim - 1);
      cd = wide ? $urandom_range(0, 4095) : $urandom_range(0, 47);
      dup = 1'b0;
      foreach (dict_ch[m]) if (dict_ch[m] == c || dict_cd[m] == cd) dup = 1'b1;
      if (!dup) begin
        dict_ch.push_back(c);
        dict_cd.push_back(cd);
        put_map(c, cd);
      end
    end
    nodes.push_back('{slot: 0, up: -1, ch: 0, depth: 0, base: 1, kids: 0, leaf: 1'b0});
    for (i = 0; i < nodes.size(); i++) begin
      nd = nodes[i];
      kid_codes.delete();
      kid_chars.delete();
      if (nd.depth < 4 && nodes.size() < 60 && (i == 0 || $urandom_range(0, 2) != 0)) begin
        k = $urandom_range(1, 3);
        for (tries = 0; tries < 10 && kid_codes.size() < k; tries++) begin
          j = $urandom_range(0, dict_ch.size() - 1);
          dup = 1'b0;
          foreach (kid_codes[m]) if (kid_codes[m] == dict_cd[j]) dup = 1'b1;
          if (!dup) begin
            kid_codes.push_back(dict_cd[j]);
            kid_chars.push_back(dict_ch[j]);
          end
        end
        maxc = 0;
        foreach (kid_codes[m]) if (kid_codes[m] > maxc) maxc = kid_codes[m];
        ok = 1'b0;
        // root base is fixed, other nodes get a random base whose child slots are free
        for (tries = 0; tries < 40 && !ok; tries++) begin
          b = (i == 0) ? 1 : $urandom_range(0, DEPTH - 1 - maxc);
          ok = 1'b1;
          foreach (kid_codes[m]) begin
            if (b + kid_codes[m] >= DEPTH) ok = 1'b0;
            else if (slot_used[b + kid_codes[m]]) ok = 1'b0;
          end
        end
        if (ok) begin
          nodes[i].base = b;
          nodes[i].kids = kid_codes.size();
          foreach (kid_codes[m]) begin
            slot_used[b + kid_codes[m]] = 1'b1;
            nodes.push_back('{slot: b + kid_codes[m], up: i, ch: kid_chars[m],
                              depth: nd.depth + 1, base: 4095, kids: 0, leaf: 1'b0});
          end
        end
      end
    end
    for (i = 1; i < nodes.size(); i++) begin
      nodes[i].leaf = (nodes[i].kids == 0) ? 1'b1 : ($urandom_range(0, 2) == 0);
      put_trie(nodes[i].slot, nodes[i].base, nodes[i].leaf, nodes[nodes[i].up].slot);
    end
  endtask

  task automatic put_key(int alpha);
    int path [$];
    int j;
    int r;
    r = $urandom_range(0, 99);
    if (nodes.size() > 1 && r < 90) begin
      j = $urandom_range(1, nodes.size() - 1);
      while (j > 0) begin
        path.push_front(nodes[j].ch);
        j = nodes[j].up;
      end
      if (r >= 70 && r < 78) begin
        path.push_back(dict_ch[$urandom_range(0, dict_ch.size() - 1)]);
      end else if (r >= 78 && r < 84) begin
        path[$urandom_range(0, path.size() - 1)] = dict_ch[$urandom_range(0, dict_ch.size() - 1)];
      end else if (r >= 84) begin
        // character at or past the alphabet size, or past the code map
        path[$urandom_range(0, path.size() - 1)] =
            $urandom_range(0, 1) ? alpha + $urandom_range(0, 2) : $urandom_range(4096, 65535);
      end
    end else begin
      repeat ($urandom_range(1, 4)) path.push_back($urandom_range(0, 65535));
    end
    foreach (path[m]) begin
      if (m > 0 && $urandom_range(0, 9) == 0) put_stray();
      put_char(path[m], m == path.size() - 1);
    end
    if ($urandom_range(0, 9) == 0) put_stray();
  endtask

  // all items taken, all results seen, then a wait for trailing loads
  task automatic settle();
    while (n_taken != n_queued || expected_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_alpha(int v);
    @(posedge clk);
    cfg_data <= 13'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    alpha_lim = v;
    cfg_valid <= 1'b0;
  endtask

  int phase_alpha [7];
  int phase_len [7];
  int ph;
  int stop_at;

  initial begin
    foreach (map_tbl[m]) begin
      map_tbl[m] = '0;
      base_tbl[m] = '0;
      leaf_tbl[m] = 1'b0;
      check_tbl[m] = CHECK_FREE;
    end
    cur_base = int'(ROOT_BASE);
    cur_parent = 0;
    key_bad = 1'b0;
    cur_leaf = 1'b0;
    alpha_lim = int'(ALPHA_RESET);
    phase_alpha = '{4096, 0, 1, 4095, $urandom_range(2, 4095), $urandom_range(16, 300), 4096};
    phase_len = '{350, 100, 150, 350, 300, 250, 150};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed part, alphabet at its reset value
    put_char(0, 1);                       // empty tables
    put_map(4095, 4095);
    put_trie(4095, 4095, 1, 4095);
    put_trie(1, 0, 1, 0);
    put_char(0, 1);                       // found at depth one
    put_char(0, 0);
    put_char(0, 1);                       // second step lands on a free entry
    put_trie(0, 0, 0, 1);
    put_char(0, 0);
    put_char(0, 1);                       // prefix only
    put_char(4095, 1);                    // index past the end of the array
    put_char(4096, 1);                    // beyond the code map
    put_char(16'hffff, 1);
    put_char(4096, 0);
    put_char(0, 1);                       // characters after a failure
    put_char(0, 0);
    put_map(5, 0);                        // loads and an ignored item mid-key
    push_item(noise_fields(KIND_NONE));
    put_trie(4000, 17, 1, -1);
    put_char(5, 1);
    put_trie(2, 4095, 1, -1);
    put_map(1, 1);
    put_char(1, 1);                       // free entry
    settle();

    for (ph = 0; ph < 7; ph++) begin
      write_alpha(phase_alpha[ph]);
      stop_at = n_real + phase_len[ph];
      while (n_real < stop_at) begin
        build_trie(phase_alpha[ph]);
        repeat (30) if (n_real < stop_at) put_key(phase_alpha[ph]);
      end
      settle();
    end

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
